### hdl/ost_pkg.sv
`timescale 1ns / 1ps
package ost_pkg;
    localparam int unsigned OP_BITS = 3;
    localparam int unsigned POS_BITS = 8;
    localparam int unsigned IN_VALUE_BITS = 32;
    localparam int unsigned CNT_BITS = 9;

    typedef enum logic [OP_BITS-1:0] {
        OP_INSERT_AT = 3'd0,
        OP_INSERT_SORTED = 3'd1,
        OP_ERASE = 3'd2,
        OP_REMOVE_ALL = 3'd3,
        OP_GET = 3'd4,
        OP_SET = 3'd5,
        OP_FIND = 3'd6,
        OP_NOP = 3'd7
    } t_op;

    typedef enum logic [1:0] {
        ST_OK = 2'd0,
        ST_BADPOS = 2'd1,
        ST_FULL = 2'd2,
        ST_NOTFOUND = 2'd3
    } t_status;

    // datapath commands from the controller
    typedef struct packed {
        logic       load;      // capture request fields
        logic       rd;        // issue memory read at r_addr
        logic       wr_val;    // write request value at r_addr
        logic       wr_data;   // write held data at r_waddr
        logic       addr_inc;
        logic       addr_dec;
        logic       addr_set_cnt; // r_addr <- count (top of list)
        logic       addr_set_pos; // r_addr <- position
        logic       addr_zero;
        logic       hold_rd;   // hold = read data
        logic       waddr_from_addr;
        logic       waddr_inc;
        logic       waddr_zero;
        logic       tgt_from_addr; // insert target <- r_addr
        logic       cnt_inc;
        logic       cnt_dec;
        logic       cnt_from_waddr;
        logic       res_ok_index_addr; // index <- r_addr
        logic       res_read;
        logic       res_removed;
        logic [1:0] res_status;
        logic       res_set;   // latch result
    } t_cmd;

    // datapath status to the controller
    typedef struct packed {
        logic       pos_gt_cnt;
        logic       pos_ge_cnt;
        logic       full;
        logic       addr_ge_cnt;  // scan done
        logic       addr_eq_pos;  // shift reached insert target
        logic       addr_last;    // addr + 1 >= count
        logic       rd_eq_val;
        logic       val_le_rd;
    } t_stat;
endpackage

### hdl/ost_if.sv
`timescale 1ns / 1ps
interface ost_req_if;
    logic                                 valid;
    logic                                 ready;
    logic [ost_pkg::OP_BITS-1:0]          operation;
    logic [ost_pkg::POS_BITS-1:0]         position;
    logic [ost_pkg::IN_VALUE_BITS-1:0]    value;
    modport source (output valid, operation, position, value, input ready);
    modport sink (input valid, operation, position, value, output ready);
endinterface

interface ost_rsp_if;
    logic                                 valid;
    logic                                 ready;
    logic [1:0]                           status;
    logic [ost_pkg::POS_BITS-1:0]         index;
    logic [ost_pkg::IN_VALUE_BITS-1:0]    read_value;
    logic [ost_pkg::CNT_BITS-1:0]         removed_count;
    logic [ost_pkg::CNT_BITS-1:0]         item_count;
    modport source (output valid, status, index, read_value, removed_count, item_count,
                    input ready);
    modport sink (input valid, status, index, read_value, removed_count, item_count,
                  output ready);
endinterface

### hdl/ost_datapath.sv
`timescale 1ns / 1ps
module ost_datapath #(
    parameter int unsigned CAPACITY = 256,
    parameter int unsigned VALUE_BITS = 32
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  ost_pkg::t_cmd                       i_cmd,
    output ost_pkg::t_stat                      o_stat,
    input  logic [ost_pkg::POS_BITS-1:0]        i_position,
    input  logic [ost_pkg::IN_VALUE_BITS-1:0]   i_value,
    output logic [1:0]                          o_status,
    output logic [ost_pkg::POS_BITS-1:0]        o_index,
    output logic [ost_pkg::IN_VALUE_BITS-1:0]   o_read_value,
    output logic [ost_pkg::CNT_BITS-1:0]        o_removed_count,
    output logic [ost_pkg::CNT_BITS-1:0]        o_item_count
);
    localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int unsigned CW = $clog2(CAPACITY + 1);
    localparam int unsigned POS_BITS_L = ost_pkg::POS_BITS;

    logic [VALUE_BITS-1:0] mem [CAPACITY];
    logic [VALUE_BITS-1:0] r_rd;
    logic [VALUE_BITS-1:0] r_val;
    logic [VALUE_BITS-1:0] r_hold;
    logic [POS_BITS_L-1:0] r_pos;
    logic [CW-1:0]         r_tgt;
    logic [CW-1:0]         r_addr;
    logic [CW-1:0]         r_waddr;
    logic [CW-1:0]         r_cnt;
    logic [CW-1:0]         pos_ext;
    logic [CW:0]           addr_p1;

    assign pos_ext = CW'(r_pos);
    assign addr_p1 = {1'b0, r_addr} + 1'b1;

    // memory: one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_val) begin
            mem[r_addr[AW-1:0]] <= r_val;
        end else if (i_cmd.wr_data) begin
            mem[r_waddr[AW-1:0]] <= r_hold;
        end
        if (i_cmd.rd) begin
            r_rd <= mem[r_addr[AW-1:0]];
        end
    end

    // request fields, address counters and held data
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_pos <= i_position;
            r_val <= VALUE_BITS'(i_value);
        end
        if (i_cmd.load) begin
            r_tgt <= CW'(i_position);
        end else if (i_cmd.tgt_from_addr) begin
            r_tgt <= r_addr;
        end
        if (i_cmd.hold_rd) begin
            r_hold <= r_rd;
        end
        if (i_cmd.addr_set_cnt) begin
            r_addr <= r_cnt;
        end else if (i_cmd.addr_set_pos) begin
            r_addr <= pos_ext;
        end else if (i_cmd.addr_zero) begin
            r_addr <= '0;
        end else if (i_cmd.addr_inc) begin
            r_addr <= addr_p1[CW-1:0];
        end else if (i_cmd.addr_dec) begin
            r_addr <= r_addr - 1'b1;
        end
        if (i_cmd.waddr_zero) begin
            r_waddr <= '0;
        end else if (i_cmd.waddr_from_addr) begin
            r_waddr <= r_addr;
        end else if (i_cmd.waddr_inc) begin
            r_waddr <= r_waddr + 1'b1;
        end
    end

    // entry count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_cmd.cnt_inc) begin
            r_cnt <= r_cnt + 1'b1;
        end else if (i_cmd.cnt_dec) begin
            r_cnt <= r_cnt - 1'b1;
        end else if (i_cmd.cnt_from_waddr) begin
            r_cnt <= r_waddr;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (i_cmd.res_set) begin
            o_status        <= i_cmd.res_status;
            o_index         <= i_cmd.res_ok_index_addr ? POS_BITS_L'(r_addr) : '0;
            o_read_value    <= i_cmd.res_read ? ost_pkg::IN_VALUE_BITS'(r_rd) : '0;
            o_removed_count <= i_cmd.res_removed ?
                               ost_pkg::CNT_BITS'(r_cnt - r_waddr) : '0;
        end
    end
    assign o_item_count = ost_pkg::CNT_BITS'(r_cnt);

    assign o_stat.pos_gt_cnt  = pos_ext > r_cnt || (POS_BITS_L > CW && (r_pos >> CW) != 0);
    assign o_stat.pos_ge_cnt  = pos_ext >= r_cnt || (POS_BITS_L > CW && (r_pos >> CW) != 0);
    assign o_stat.full        = r_cnt >= CW'(CAPACITY);
    assign o_stat.addr_ge_cnt = r_addr >= r_cnt;
    assign o_stat.addr_eq_pos = r_addr == r_tgt;
    assign o_stat.addr_last   = addr_p1 >= {1'b0, r_cnt};
    assign o_stat.rd_eq_val   = r_rd == r_val;
    assign o_stat.val_le_rd   = r_val <= r_rd;
endmodule

### hdl/ost_ctrl.sv
`timescale 1ns / 1ps
module ost_ctrl (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic [ost_pkg::OP_BITS-1:0] i_operation,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output ost_pkg::t_cmd               o_cmd,
    input  ost_pkg::t_stat              i_stat
);
    typedef enum logic [3:0] {
        S_IDLE, S_DECODE, S_SCAN_RD, S_SCAN_WAIT, S_SCAN_CHK,
        S_SHUP_RD, S_SHUP_WAIT, S_SHUP_WR, S_INS,
        S_SHDN_RD, S_SHDN_WAIT, S_SHDN_WR,
        S_RM_RD, S_RM_WAIT, S_RM_CHK, S_DONE
    } t_state;

    t_state r_state, n_state;
    ost_pkg::t_op r_op;
    logic r_out_valid;

    assign o_in_ready  = (r_state == S_IDLE) && !r_out_valid;
    assign o_out_valid = r_out_valid;

    // command decode
    always_comb begin
        o_cmd = '0;
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid && o_in_ready) begin
                    o_cmd.load = 1'b1;
                    n_state = S_DECODE;
                end
            end
            S_DECODE: begin
                case (r_op)
                    ost_pkg::OP_INSERT_AT: begin
                        if (i_stat.pos_gt_cnt) begin
                            o_cmd.res_status = ost_pkg::ST_BADPOS;
                            o_cmd.res_set = 1'b1;
                            n_state = S_DONE;
                        end else if (i_stat.full) begin
                            o_cmd.res_status = ost_pkg::ST_FULL;
                            o_cmd.res_set = 1'b1;
                            n_state = S_DONE;
                        end else begin
                            o_cmd.addr_set_cnt = 1'b1;
                            n_state = S_SHUP_RD;
                        end
                    end
                    ost_pkg::OP_INSERT_SORTED: begin
                        if (i_stat.full) begin
                            o_cmd.res_status = ost_pkg::ST_FULL;
                            o_cmd.res_set = 1'b1;
                            n_state = S_DONE;
                        end else begin
                            o_cmd.addr_zero = 1'b1;
                            n_state = S_SCAN_RD;
                        end
                    end
                    ost_pkg::OP_FIND: begin
                        o_cmd.addr_zero = 1'b1;
                        n_state = S_SCAN_RD;
                    end
                    ost_pkg::OP_ERASE: begin
                        if (i_stat.pos_ge_cnt) begin
                            o_cmd.res_status = ost_pkg::ST_BADPOS;
                            o_cmd.res_set = 1'b1;
                            n_state = S_DONE;
                        end else begin
                            o_cmd.addr_set_pos = 1'b1;
                            n_state = S_SHDN_RD;
                        end
                    end
                    ost_pkg::OP_REMOVE_ALL: begin
                        o_cmd.addr_zero = 1'b1;
                        o_cmd.waddr_zero = 1'b1;
                        n_state = S_RM_RD;
                    end
                    ost_pkg::OP_GET, ost_pkg::OP_SET: begin
                        if (i_stat.pos_ge_cnt) begin
                            o_cmd.res_status = ost_pkg::ST_BADPOS;
                            o_cmd.res_set = 1'b1;
                            n_state = S_DONE;
                        end else begin
                            o_cmd.addr_set_pos = 1'b1;
                            n_state = S_SCAN_RD;
                        end
                    end
                    default: begin
                        o_cmd.res_status = ost_pkg::ST_OK;
                        o_cmd.res_set = 1'b1;
                        n_state = S_DONE;
                    end
                endcase
            end
            // scan: get/set single access, find and sorted search
            S_SCAN_RD: begin
                if (r_op == ost_pkg::OP_SET) begin
                    o_cmd.wr_val = 1'b1;
                    o_cmd.res_status = ost_pkg::ST_OK;
                    o_cmd.res_set = 1'b1;
                    n_state = S_DONE;
                end else if (r_op != ost_pkg::OP_GET && i_stat.addr_ge_cnt) begin
                    if (r_op == ost_pkg::OP_FIND) begin
                        o_cmd.res_status = ost_pkg::ST_NOTFOUND;
                        o_cmd.res_set = 1'b1;
                        n_state = S_DONE;
                    end else begin
                        o_cmd.tgt_from_addr = 1'b1;
                        n_state = S_INS;
                    end
                end else begin
                    o_cmd.rd = 1'b1;
                    n_state = S_SCAN_WAIT;
                end
            end
            S_SCAN_WAIT: n_state = S_SCAN_CHK;
            S_SCAN_CHK: begin
                if (r_op == ost_pkg::OP_GET) begin
                    o_cmd.res_read = 1'b1;
                    o_cmd.res_status = ost_pkg::ST_OK;
                    o_cmd.res_set = 1'b1;
                    n_state = S_DONE;
                end else if (r_op == ost_pkg::OP_FIND && i_stat.rd_eq_val) begin
                    o_cmd.res_ok_index_addr = 1'b1;
                    o_cmd.res_status = ost_pkg::ST_OK;
                    o_cmd.res_set = 1'b1;
                    n_state = S_DONE;
                end else if (r_op == ost_pkg::OP_INSERT_SORTED && i_stat.val_le_rd) begin
                    // gap opens here: shift from the top down to this point
                    o_cmd.tgt_from_addr = 1'b1;
                    n_state = S_INS;
                end else begin
                    o_cmd.addr_inc = 1'b1;
                    n_state = S_SCAN_RD;
                end
            end
            // S_INS: sorted insert keeps target in r_tgt, restart from top
            S_INS: begin
                o_cmd.addr_set_cnt = 1'b1;
                n_state = S_SHUP_RD;
            end
            // shift up: addr walks from count down to target position
            S_SHUP_RD: begin
                if ((r_op == ost_pkg::OP_INSERT_AT && i_stat.addr_eq_pos) ||
                    (r_op == ost_pkg::OP_INSERT_SORTED && i_stat.addr_eq_pos)) begin
                    o_cmd.wr_val = 1'b1;
                    o_cmd.cnt_inc = 1'b1;
                    o_cmd.res_ok_index_addr = 1'b1;
                    o_cmd.res_status = ost_pkg::ST_OK;
                    o_cmd.res_set = 1'b1;
                    n_state = S_DONE;
                end else begin
                    o_cmd.addr_dec = 1'b1;
                    o_cmd.waddr_from_addr = 1'b1;
                    n_state = S_SHUP_WAIT;
                end
            end
            S_SHUP_WAIT: begin
                o_cmd.rd = 1'b1;
                n_state = S_SHUP_WR;
            end
            S_SHUP_WR: begin
                o_cmd.hold_rd = 1'b1;
                n_state = S_SHDN_WAIT;
            end
            // shift down: entry[addr] <- entry[addr+1]
            S_SHDN_RD: begin
                if (i_stat.addr_last) begin
                    o_cmd.cnt_dec = 1'b1;
                    o_cmd.res_status = ost_pkg::ST_OK;
                    o_cmd.res_set = 1'b1;
                    n_state = S_DONE;
                end else begin
                    o_cmd.waddr_from_addr = 1'b1;
                    o_cmd.addr_inc = 1'b1;
                    n_state = S_SHDN_WR;
                end
            end
            S_SHDN_WR: begin
                o_cmd.rd = 1'b1;
                n_state = S_RM_WAIT;
            end
            S_RM_WAIT: begin
                if (r_op == ost_pkg::OP_ERASE) begin
                    n_state = S_SHDN_WAIT;
                end else begin
                    n_state = S_RM_CHK;
                end
            end
            S_SHDN_WAIT: begin
                // shared state: erase holds the read data; remove_all and shift up write back held data
                if (r_op == ost_pkg::OP_ERASE) begin
                    o_cmd.hold_rd = 1'b1;
                    n_state = S_DONE;
                end else if (r_op == ost_pkg::OP_REMOVE_ALL) begin
                    o_cmd.wr_data = 1'b1;
                    o_cmd.waddr_inc = 1'b1;
                    n_state = S_RM_RD;
                end else begin
                    o_cmd.wr_data = 1'b1;
                    n_state = S_SHUP_RD;
                end
            end
            // remove_all: read pointer r_addr, write pointer r_waddr
            S_RM_RD: begin
                if (i_stat.addr_ge_cnt) begin
                    o_cmd.res_removed = 1'b1;
                    o_cmd.res_status = ost_pkg::ST_OK;
                    o_cmd.res_set = 1'b1;
                    o_cmd.cnt_from_waddr = 1'b1;
                    n_state = S_DONE;
                end else begin
                    o_cmd.rd = 1'b1;
                    n_state = S_RM_WAIT;
                end
            end
            S_RM_CHK: begin
                o_cmd.hold_rd = 1'b1;
                o_cmd.addr_inc = 1'b1;
                n_state = i_stat.rd_eq_val ? S_RM_RD : S_SHDN_WAIT;
            end
            S_DONE: begin
                if (r_op == ost_pkg::OP_ERASE && !r_out_valid) begin
                    o_cmd.wr_data = 1'b1;
                    n_state = S_SHDN_RD;
                end else if (r_out_valid && i_out_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // state, operation and registered output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_op <= ost_pkg::OP_NOP;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_cmd.load) begin
                r_op <= ost_pkg::t_op'(i_operation);
            end
            if (o_cmd.res_set) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    a_ready_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready |-> r_state == S_IDLE) else $error("ready outside idle");
    a_valid_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> r_state == S_DONE) else $error("result outside done");
    a_single_res: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> !o_cmd.res_set) else $error("second result");
endmodule

### hdl/ordered_sequence_table_unit.sv
`timescale 1ns / 1ps
// rejected operations and the no-op finish straight from decode; set writes and get reads
// one entry; find scans from the start, inserts scan and shift, remove_all scans and
//   compacts, and erase shifts every entry above the position, so their run time grows
//   with the entries scanned or shifted
// operations are handled one at a time; the next is accepted in the cycle after the result transfer
// reset: synchronous active-low clears count and control; entries stay undefined until written
module ordered_sequence_table_unit #(
    parameter int unsigned CAPACITY = 256,
    parameter int unsigned VALUE_BITS = 32
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    ost_req_if.sink    i_req,
    ost_rsp_if.source  o_rsp
);
    ost_pkg::t_cmd  cmd;
    ost_pkg::t_stat stat;

    ost_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_req.valid),
        .o_in_ready  (i_req.ready),
        .i_operation (i_req.operation),
        .o_out_valid (o_rsp.valid),
        .i_out_ready (o_rsp.ready),
        .o_cmd       (cmd),
        .i_stat      (stat)
    );

    ost_datapath #(.CAPACITY(CAPACITY), .VALUE_BITS(VALUE_BITS)) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_stat          (stat),
        .i_position      (i_req.position),
        .i_value         (i_req.value),
        .o_status        (o_rsp.status),
        .o_index         (o_rsp.index),
        .o_read_value    (o_rsp.read_value),
        .o_removed_count (o_rsp.removed_count),
        .o_item_count    (o_rsp.item_count)
    );
endmodule

### tb/testbench.sv
`timescale 1ns / 1ps
module testbench;
    localparam int unsigned CAP = 256;
    localparam int unsigned WATCHDOG_LIMIT = 20000;

    typedef struct packed {
        ost_pkg::t_status status;
        logic [7:0]       index;
        logic [31:0]      read_value;
        logic [8:0]       removed_count;
        logic [8:0]       item_count;
    } t_result;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    ost_req_if req_if ();
    ost_rsp_if rsp_if ();

    ordered_sequence_table_unit #(.CAPACITY(CAP), .VALUE_BITS(32)) DUT (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (req_if.sink),
        .o_rsp  (rsp_if.source)
    );

    always #5 i_clk = ~i_clk;

    // shadow list and pending results
    logic [31:0] list_mem [CAP];
    int unsigned list_len;
    t_result     pending_q[$];
    int unsigned send_idle_pct;
    int unsigned recv_idle_pct;
    int unsigned error_count;
    int unsigned quiet_cycles;

    // predict one operation and update the shadow list
    function automatic t_result apply_op(ost_pkg::t_op op, logic [7:0] pos,
                                         logic [31:0] val);
        t_result r;
        int unsigned i;
        int unsigned j;
        r = '0;
        r.status = ost_pkg::ST_OK;
        case (op)
            ost_pkg::OP_INSERT_AT, ost_pkg::OP_INSERT_SORTED: begin
                if (op == ost_pkg::OP_INSERT_AT && pos > list_len) begin
                    r.status = ost_pkg::ST_BADPOS;
                end else if (list_len >= CAP) begin
                    r.status = ost_pkg::ST_FULL;
                end else begin
                    if (op == ost_pkg::OP_INSERT_AT) begin
                        j = 32'(pos);
                    end else begin
                        for (j = 0; j < list_len; j++)
                            if (val <= list_mem[j]) break;
                    end
                    for (i = list_len; i > j; i--) list_mem[i] = list_mem[i-1];
                    list_mem[j] = val;
                    list_len++;
                    r.index = j[7:0];
                end
            end
            ost_pkg::OP_ERASE: begin
                if (pos >= list_len) begin
                    r.status = ost_pkg::ST_BADPOS;
                end else begin
                    for (i = 32'(pos); i + 1 < list_len; i++) list_mem[i] = list_mem[i+1];
                    list_len--;
                end
            end
            ost_pkg::OP_REMOVE_ALL: begin
                j = 0;
                for (i = 0; i < list_len; i++)
                    if (list_mem[i] != val) list_mem[j++] = list_mem[i];
                r.removed_count = 9'(list_len - j);
                list_len = j;
            end
            ost_pkg::OP_GET: begin
                if (pos >= list_len) r.status = ost_pkg::ST_BADPOS;
                else r.read_value = list_mem[pos];
            end
            ost_pkg::OP_SET: begin
                if (pos >= list_len) r.status = ost_pkg::ST_BADPOS;
                else list_mem[pos] = val;
            end
            ost_pkg::OP_FIND: begin
                r.status = ost_pkg::ST_NOTFOUND;
                for (i = 0; i < list_len; i++) begin
                    if (list_mem[i] == val) begin
                        r.status = ost_pkg::ST_OK;
                        r.index = i[7:0];
                        break;
                    end
                end
            end
            default: ;
        endcase
        r.item_count = 9'(list_len);
        return r;
    endfunction

    // send one operation and record its expected result
    task automatic send_op(ost_pkg::t_op op, logic [7:0] pos, logic [31:0] val);
        while ($urandom_range(99) < send_idle_pct) begin
            req_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        req_if.valid     <= 1'b1;
        req_if.operation <= op;
        req_if.position  <= pos;
        req_if.value     <= val;
        do @(posedge i_clk); while (!req_if.ready);
        pending_q.push_back(apply_op(op, pos, val));
    endtask

    task automatic drain();
        req_if.valid <= 1'b0;
        while (pending_q.size() != 0) @(posedge i_clk);
    endtask

    // receiver stalls at random
    always @(posedge i_clk) begin
        if (!i_rst_n) rsp_if.ready <= 1'b0;
        else rsp_if.ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // compare each result transfer with the oldest expectation
    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        if (i_rst_n && rsp_if.valid && rsp_if.ready) begin
            got = {ost_pkg::t_status'(rsp_if.status), rsp_if.index, rsp_if.read_value,
                   rsp_if.removed_count, rsp_if.item_count};
            if (pending_q.size() == 0) begin
                $display("%0t: unexpected result %h", $time, got);
                error_count++;
            end else begin
                want = pending_q.pop_front();
                if (got.status != want.status || got.index != want.index
                    || got.read_value != want.read_value
                    || got.removed_count != want.removed_count
                    || got.item_count != want.item_count) begin
                    $display("%0t: mismatch expected st=%0d idx=%0d rd=%h rm=%0d cnt=%0d",
                             $time, want.status, want.index, want.read_value,
                             want.removed_count, want.item_count);
                    $display("%0t:          actual   st=%0d idx=%0d rd=%h rm=%0d cnt=%0d",
                             $time, got.status, got.index, got.read_value,
                             got.removed_count, got.item_count);
                    error_count++;
                end
            end
        end
    end

    // watchdog on cycles with no transfer
    always @(posedge i_clk) begin
        if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("ordered_sequence_table_unit verification failed");
            $finish;
        end
    end

    // value mostly from a small pool, sometimes fully random, so matches and duplicates happen
    function automatic logic [31:0] pick_value();
        case ($urandom_range(3))
            0: return 32'($urandom_range(7));
            1: return $urandom();
            2: return 32'hFFFF_FFF8 | 32'($urandom_range(7));
            default: return (list_len > 0) ? list_mem[$urandom_range(list_len - 1)]
                                            : 32'($urandom_range(7));
        endcase
    endfunction

    function automatic logic [7:0] pick_pos();
        if ($urandom_range(9) == 0) return 8'($urandom());
        return 8'($urandom_range(list_len));
    endfunction

    task automatic test_directed();
        send_op(ost_pkg::OP_GET, 8'd0, 32'd0);
        send_op(ost_pkg::OP_ERASE, 8'd0, 32'd0);
        send_op(ost_pkg::OP_SET, 8'd255, 32'hFFFF_FFFF);
        send_op(ost_pkg::OP_FIND, 8'd0, 32'd5);
        send_op(ost_pkg::OP_REMOVE_ALL, 8'd0, 32'd5);
        send_op(ost_pkg::OP_INSERT_AT, 8'd1, 32'd1);
        send_op(ost_pkg::OP_INSERT_AT, 8'd0, 32'hFFFF_FFFF);
        send_op(ost_pkg::OP_INSERT_AT, 8'd0, 32'd0);
        send_op(ost_pkg::OP_INSERT_SORTED, 8'd0, 32'h8000_0000);
        send_op(ost_pkg::OP_INSERT_SORTED, 8'd0, 32'h8000_0000);
        send_op(ost_pkg::OP_INSERT_SORTED, 8'd0, 32'hFFFF_FFFF);
        send_op(ost_pkg::OP_GET, 8'd4, 32'd0);
        send_op(ost_pkg::OP_SET, 8'd1, 32'hA5A5_5A5A);
        send_op(ost_pkg::OP_GET, 8'd1, 32'd0);
        send_op(ost_pkg::OP_FIND, 8'd0, 32'hFFFF_FFFF);
        send_op(ost_pkg::OP_FIND, 8'd0, 32'h1234_5678);
        send_op(ost_pkg::OP_REMOVE_ALL, 8'd0, 32'hFFFF_FFFF);
        send_op(ost_pkg::OP_ERASE, 8'd2, 32'd0);
        send_op(ost_pkg::OP_ERASE, 8'd9, 32'd0);
        send_op(ost_pkg::OP_NOP, 8'hFF, 32'hFFFF_FFFF);
        drain();
    endtask

    // fill to capacity, hit the full flag, then empty again
    task automatic test_full_list();
        while (list_len < CAP)
            send_op(($urandom_range(1) != 0) ? ost_pkg::OP_INSERT_SORTED
                                             : ost_pkg::OP_INSERT_AT,
                    8'($urandom_range(list_len)), 32'($urandom_range(15)));
        send_op(ost_pkg::OP_INSERT_AT, 8'd255, 32'd1);
        send_op(ost_pkg::OP_INSERT_SORTED, 8'd0, 32'd1);
        send_op(ost_pkg::OP_GET, 8'd255, 32'd0);
        send_op(ost_pkg::OP_SET, 8'd255, 32'hFFFF_FFFF);
        send_op(ost_pkg::OP_FIND, 8'd0, 32'hFFFF_FFFF);
        for (int unsigned v = 0; v < 16; v++)
            send_op(ost_pkg::OP_REMOVE_ALL, 8'd0, 32'(v));
        send_op(ost_pkg::OP_REMOVE_ALL, 8'd0, 32'hFFFF_FFFF);
        drain();
    endtask

    task automatic test_random(int unsigned n);
        ost_pkg::t_op op;
        for (int unsigned k = 0; k < n; k++) begin
            op = ost_pkg::t_op'($urandom_range(7));
            // keep the list from emptying too often
            if (list_len < 4 && $urandom_range(1) != 0) op = ost_pkg::OP_INSERT_SORTED;
            if (op == ost_pkg::OP_REMOVE_ALL && $urandom_range(3) != 0)
                op = ost_pkg::OP_FIND;
            send_op(op, pick_pos(), pick_value());
        end
        drain();
    endtask

    initial begin
        req_if.valid     <= 1'b0;
        req_if.operation <= ost_pkg::OP_NOP;
        req_if.position  <= '0;
        req_if.value     <= '0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        error_count = 0;
        quiet_cycles = 0;
        list_len = 0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_idle_pct = 37;
        recv_idle_pct = 52;
        test_directed();
        test_random(80);
        send_idle_pct = 52;
        recv_idle_pct = 37;
        test_full_list();
        test_random(80);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random(80);

        repeat (20) @(posedge i_clk);
        if (error_count == 0 && pending_q.size() == 0)
            $display("ordered_sequence_table_unit verification clean");
        else
            $display("ordered_sequence_table_unit verification failed");
        $finish;
    end
endmodule
